// ===== rtl/wnaf_pkg.sv =====
// Shared constants and controller/datapath interface types for the wNAF recoder.
package wnaf_pkg;

  localparam int MAX_DIGITS = 64;
  localparam int MAX_WINDOW = 8;
  localparam int MIN_WINDOW = 2;

  localparam int SCALAR_W = 63;
  localparam int WORK_W   = 64;
  localparam int DIGIT_W  = 8;
  localparam int WIN_W    = 4;
  localparam int CNT_W    = 7;
  localparam int ADDR_W   = $clog2(MAX_DIGITS);
  localparam int MOD_W    = MAX_WINDOW + 1;

  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(4);

  typedef struct packed {
    logic load;        // take a new scalar, clear the digit count
    logic step;        // produce one digit and shift the working value
    logic fetch_first; // read the most significant digit
    logic fetch_next;  // read the next lower digit
  } wnaf_cmd_t;

  typedef struct packed {
    logic work_zero;
    logic count_full;
    logic count_zero;
    logic idx_zero;
  } wnaf_status_t;

endpackage : wnaf_pkg

// ===== rtl/wnaf_dp.sv =====
// Datapath: working value, digit store, digit count and read-out index.
module wnaf_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wnaf_pkg::WIN_W-1:0]   cfg_window,
  input  logic [wnaf_pkg::SCALAR_W-1:0] scalar,
  input  wnaf_pkg::wnaf_cmd_t          cmd,
  output wnaf_pkg::wnaf_status_t       status,
  output logic signed [wnaf_pkg::DIGIT_W-1:0] digit,
  output logic                         last_digit
);
  import wnaf_pkg::*;

  logic [WIN_W-1:0]   window;
  logic [WIN_W-1:0]   w_eff;
  logic [WORK_W-1:0]  work;
  logic [WORK_W-1:0]  work_next;
  logic [CNT_W-1:0]   count;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  rd_addr;
  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data;

  logic [MOD_W-1:0]   modulus;
  logic [MOD_W-1:0]   half;
  logic [MOD_W-1:0]   resid;
  logic [MOD_W-1:0]   delta;
  logic [MOD_W-1:0]   digit_wide;
  logic               neg;
  logic [WORK_W-1:0]  adjusted;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WIN_RESET;
    end else if (cfg_we) begin
      window <= cfg_window;
    end
  end

  always_comb begin
    if (window < WIN_W'(MIN_WINDOW)) begin
      w_eff = WIN_W'(MIN_WINDOW);
    end else if (window > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = window;
    end
  end

  // One recoding step: the low window of an odd value, taken as a signed residue,
  // becomes the digit; subtracting that digit clears the window, and the value shifts right.
  always_comb begin
    modulus = MOD_W'(1) << w_eff;
    half    = modulus >> 1;
    resid   = {1'b0, work[MOD_W-2:0]} & (modulus - MOD_W'(1));
    neg     = work[0] && (resid >= half);
    if (!work[0]) begin
      digit_wide = '0;
      delta      = '0;
    end else if (neg) begin
      digit_wide = resid - modulus;
      delta      = modulus - resid;
    end else begin
      digit_wide = resid;
      delta      = resid;
    end
    if (neg) begin
      adjusted = work + WORK_W'(delta);
    end else begin
      adjusted = work - WORK_W'(delta);
    end
    work_next = adjusted >> 1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work  <= '0;
      count <= '0;
    end else if (cmd.load) begin
      work  <= WORK_W'(scalar);
      count <= '0;
    end else if (cmd.step) begin
      work  <= work_next;
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      mem[count[ADDR_W-1:0]] <= digit_wide[DIGIT_W-1:0];
    end
  end

  assign rd_addr = cmd.fetch_first ? ADDR_W'(count - CNT_W'(1)) : idx - ADDR_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.fetch_first || cmd.fetch_next) begin
      rd_data <= mem[rd_addr];
      idx     <= rd_addr;
    end
  end

  assign status.work_zero  = (work == '0);
  assign status.count_full = (count == CNT_W'(MAX_DIGITS));
  assign status.count_zero = (count == '0);
  assign status.idx_zero   = (idx == '0);

  assign digit      = $signed(rd_data);
  assign last_digit = (idx == '0);

endmodule : wnaf_dp

// ===== rtl/wnaf_ctrl.sv =====
// Controller state machine sequencing load, recoding steps and digit read-out.
module wnaf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  wnaf_pkg::wnaf_status_t status,
  output wnaf_pkg::wnaf_cmd_t    cmd
);
  import wnaf_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECODE,
    ST_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RECODE;
        end
      end
      ST_RECODE: begin
        if (status.work_zero || status.count_full) begin
          if (status.count_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.fetch_first = 1'b1;
            state_next      = ST_SHOW;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_SHOW: begin
        // The next lower digit is read on the same edge that hands this one off.
        if (out_ready) begin
          if (status.idx_zero) begin
            state_next = ST_IDLE;
          end else begin
            cmd.fetch_next = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_SHOW);

endmodule : wnaf_ctrl

// ===== rtl/wnaf_scalar_recoder_core.sv =====
// Top level of the width-w NAF scalar recoder.
// A scalar is loaded and recoded one digit per step (at most 64 digits); the top digit
// is then read, and digits follow one per cycle while the sink is ready. A new scalar
// is taken only once the last digit has been handed off; a zero scalar yields no beat.
// The config port takes a beat only when idle.
// Reset is synchronous and active high; the window returns to 4, the block to idle.
module wnaf_scalar_recoder_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wnaf_pkg::WIN_W-1:0]    window_width,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [wnaf_pkg::SCALAR_W-1:0] scalar,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [wnaf_pkg::DIGIT_W-1:0] digit,
  output logic                          last_digit
);
  import wnaf_pkg::*;

  wnaf_cmd_t    cmd;
  wnaf_status_t status;

  // The window may only change between scalars, never during a recoding run.
  assign cfg_ready = in_ready;

  wnaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  wnaf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_window (window_width),
    .scalar     (scalar),
    .cmd        (cmd),
    .status     (status),
    .digit      (digit),
    .last_digit (last_digit)
  );

endmodule : wnaf_scalar_recoder_core

// ===== rtl/wnaf_checker.sv =====
// Port-level checker for the wNAF recoder, bound to the top level.
module wnaf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [wnaf_pkg::SCALAR_W-1:0] scalar,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [wnaf_pkg::DIGIT_W-1:0] digit,
  input logic                          last_digit
);

  // The block never takes a new scalar while it still shows a digit.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready while a digit beat is pending");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still ready after a scalar beat");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_digit) |=> !out_valid)
    else $error("digit beat follows the last digit");

  // A zero scalar produces no digits and the block returns to idle straight from recoding.
  a_zero_scalar: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (scalar == '0)) |=> !out_valid ##1 in_ready)
    else $error("zero scalar did not return to idle without output");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(digit) && $stable(last_digit))
    else $error("stalled digit beat changed");

endmodule : wnaf_checker

bind wnaf_scalar_recoder_core wnaf_checker u_wnaf_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .scalar     (scalar),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .digit      (digit),
  .last_digit (last_digit)
);
